### design/oaids_pkg.sv
package oaids_pkg;

    localparam int OPCODE_W  = 3;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;
    localparam int DEPTH_DEF = 64;
    localparam int SCAN_GW   = 32;

    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       entry_count;
    } out_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

endpackage

### design/oaids_cell.sv
module oaids_cell #(
    parameter int IW = $clog2(oaids_pkg::DEPTH_DEF),
    parameter int MW = oaids_pkg::POS_W
) (
    input  logic                              aclk,
    input  logic [IW-1:0]                     idx,
    input  logic [MW-1:0]                     pos,
    input  logic [MW-1:0]                     count,
    input  oaids_pkg::cell_ctl_t              ctl,
    input  logic [oaids_pkg::DATA_W-1:0]      value,
    input  logic [oaids_pkg::DATA_W-1:0]      left,
    input  logic [oaids_pkg::DATA_W-1:0]      right,
    output logic [oaids_pkg::DATA_W-1:0]      entry,
    output logic                              match
);
    import oaids_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [MW-1:0]     idx_ext;
    logic              here;
    logic              above;

    assign idx_ext = MW'(idx);
    assign here    = (idx_ext == pos);
    assign above   = (idx_ext > pos);

    always_comb begin
        entry_next = entry_reg;
        if (ctl.shift_up) begin
            if (above) begin
                entry_next = left;
            end else if (here) begin
                entry_next = value;
            end
        end else if (ctl.shift_down) begin
            if (above || here) begin
                entry_next = right;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (idx_ext < count) && (entry_reg == value);

endmodule

### design/ordered_array_insert_delete_search.sv
// Channel | Ports                   | Transaction
// input   | s_valid s_ready s_data  | one operation: opcode, position, item_value
// result  | m_valid m_ready m_data  | one result: status, found, read_value, entry_count
//
// Clear, insert, delete, read and unused opcodes need no scan; one may enter every
// cycle while s_ready is high. A search stalls input, ORing match bits 32 per cycle.
// Reset clears the live count and all control; cell contents are left as they are.
// Results wait in a two-deep output stage; input also stalls when both places are held.
module ordered_array_insert_delete_search #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  oaids_pkg::in_t    s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output oaids_pkg::out_t   m_data
);
    import oaids_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int MW  = (CW > POS_W) ? CW : POS_W;
    localparam int NG  = (DEPTH + SCAN_GW - 1) / SCAN_GW;
    localparam int SW  = NG * SCAN_GW;
    localparam int GCW = $clog2(NG + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SW-1:0]     scan_reg, scan_next;
    logic [GCW-1:0]    grp_reg, grp_next;
    logic              hit_reg, hit_next;
    out_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;
    out_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic [DATA_W-1:0] entries [DEPTH];
    logic [DEPTH-1:0]  match_bits;
    cell_ctl_t         ctl;
    logic              accept;
    logic              out_load;
    logic [MW-1:0]     pos_ext;
    logic [MW-1:0]     count_ext;
    logic [MW-1:0]     count_new_ext;
    logic              is_full;
    logic              ins_ok;
    logic              del_ok;
    logic              rd_ok;
    logic [STATUS_W-1:0] status;
    logic              group_hit;

    assign pos_ext   = MW'(s_data.position);
    assign count_ext = MW'(count_reg);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign ins_ok    = !is_full && (pos_ext <= count_ext);
    assign del_ok    = (pos_ext < count_ext);
    assign rd_ok     = (pos_ext < count_ext);

    assign out_load = res_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = (state_reg == S_IDLE) && (!res_valid_reg || out_load);
    assign accept   = s_valid && s_ready;

    assign ctl.shift_up   = accept && (s_data.opcode == OP_INSERT) && ins_ok;
    assign ctl.shift_down = accept && (s_data.opcode == OP_DELETE) && del_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] left_w;
            logic [DATA_W-1:0] right_w;
            if (gi == 0) begin : g_first
                assign left_w = '0;
            end else begin : g_mid_l
                assign left_w = entries[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = entries[gi+1];
            end
            oaids_cell #(
                .IW (IW),
                .MW (MW)
            ) u_cell (
                .aclk  (aclk),
                .idx   (IW'(gi)),
                .pos   (pos_ext),
                .count (count_ext),
                .ctl   (ctl),
                .value (s_data.item_value),
                .left  (left_w),
                .right (right_w),
                .entry (entries[gi]),
                .match (match_bits[gi])
            );
        end
    endgenerate

    assign group_hit = |scan_reg[SCAN_GW-1:0];

    always_comb begin
        status     = ST_OK;
        count_next = count_reg;
        case (s_data.opcode)
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_INSERT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else if (!ins_ok) begin
                    status = ST_RANGE;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DELETE: begin
                if (!del_ok) begin
                    status = ST_RANGE;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ: begin
                if (!rd_ok) begin
                    status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    assign count_new_ext = MW'(count_next);

    always_comb begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        grp_next       = grp_reg;
        hit_next       = hit_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_load) begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
            res_valid_next = 1'b0;
        end else if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_data.opcode == OP_SEARCH) begin
                        scan_next  = SW'(match_bits);
                        grp_next   = GCW'(NG);
                        hit_next   = 1'b0;
                        state_next = S_SCAN;
                    end else begin
                        res_next.status      = status;
                        res_next.found       = 1'b0;
                        res_next.read_value  = ((s_data.opcode == OP_READ) && rd_ok) ?
                                               entries[pos_ext[IW-1:0]] : '0;
                        res_next.entry_count = count_new_ext[COUNT_W-1:0];
                        res_valid_next       = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                hit_next  = hit_reg | group_hit;
                scan_next = scan_reg >> SCAN_GW;
                grp_next  = grp_reg - GCW'(1);
                if (grp_reg == GCW'(1)) begin
                    res_next.status      = ST_OK;
                    res_next.found       = hit_reg | group_hit;
                    res_next.read_value  = '0;
                    res_next.entry_count = count_ext[COUNT_W-1:0];
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            grp_reg       <= '0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (accept) begin
                count_reg <= count_next;
            end
            grp_reg       <= grp_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### verif/ordered_array_insert_delete_search_tb.sv
`timescale 1ns / 1ps

module ordered_array_insert_delete_search_tb;
    import oaids_pkg::*;

    localparam int                  CELLS        = DEPTH_DEF;
    localparam int                  RANDOM_OPS   = 1650;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;

    class store_tracker;
        logic signed [DATA_W-1:0] cells [CELLS];
        int unsigned              live;
        out_t                     awaited_results [$];
        int                       errors;

        function new();
            live   = 0;
            errors = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        // Apply one accepted operation to the shadow store and queue its result.
        function void take_op(in_t op);
            out_t        res;
            int unsigned pos;
            int unsigned i;
            res = '0;
            res.status = ST_OK;
            pos = 32'(op.position);
            case (op.opcode)
                OP_CLEAR: begin
                    live = 0;
                end
                OP_INSERT: begin
                    if (live >= CELLS) begin
                        res.status = ST_FULL;
                    end else if (pos > live) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = live; i > pos; i--) cells[i] = cells[i-1];
                        cells[pos] = op.item_value;
                        live++;
                    end
                end
                OP_DELETE: begin
                    if (pos >= live) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = pos; i + 1 < live; i++) cells[i] = cells[i+1];
                        live--;
                    end
                end
                OP_SEARCH: begin
                    for (i = 0; i < live; i++)
                        if (cells[i] == op.item_value) res.found = 1'b1;
                end
                OP_READ: begin
                    if (pos >= live) res.status = ST_RANGE;
                    else res.read_value = cells[pos];
                end
                default: ;
            endcase
            res.entry_count = live[COUNT_W-1:0];
            awaited_results.push_back(res);
        endfunction

        function void check_result(out_t got);
            out_t exp;
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual %p", $time, got);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status: expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.found !== exp.found) begin
                $display("%0t: found: expected %0d actual %0d", $time, exp.found, got.found);
                errors++;
            end
            if (got.read_value !== exp.read_value) begin
                $display("%0t: read_value: expected %0d actual %0d", $time,
                         exp.read_value, got.read_value);
                errors++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $display("%0t: entry_count: expected %0d actual %0d", $time,
                         exp.entry_count, got.entry_count);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function logic signed [DATA_W-1:0] live_value();
            return cells[$urandom_range(live - 1)];
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    in_t          s_data;
    logic         m_valid;
    logic         m_ready;
    out_t         m_data;

    store_tracker tracker;
    int           idle_pct;
    int           stall_pct;
    bit           growing;

    ordered_array_insert_delete_search i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
    end

    function automatic in_t make_op(logic [OPCODE_W-1:0] opc, logic [POS_W-1:0] pos,
                                    logic signed [DATA_W-1:0] val);
        in_t op;
        op.opcode     = opc;
        op.position   = pos;
        op.item_value = val;
        return op;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(9);
        case (r)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return $signed($urandom_range(7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Alternate between filling and draining so the store reaches both full and empty.
    function automatic in_t next_random_op();
        int unsigned              r;
        int unsigned              limit;
        logic [OPCODE_W-1:0]      opc;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        if (growing && tracker.live == CELLS && $urandom_range(7) == 0) growing = 1'b0;
        else if (!growing && tracker.live == 0 && $urandom_range(3) == 0) growing = 1'b1;
        else if ($urandom_range(149) == 0) growing = !growing;

        r = $urandom_range(99);
        if (r == 0) opc = OP_CLEAR;
        else if (r < 3) opc = OP_UNUSED_LO + OPCODE_W'($urandom_range(2));
        else if (r < (growing ? 60 : 18)) opc = OP_INSERT;
        else if (r < 70) opc = OP_DELETE;
        else if (r < 85) opc = OP_SEARCH;
        else opc = OP_READ;

        limit = (opc == OP_INSERT) ? tracker.live : (tracker.live == 0 ? 0 : tracker.live - 1);
        r = $urandom_range(99);
        if (r < 12) pos = POS_W'($urandom_range(127));
        else if (r < 20) pos = POS_W'(limit + $urandom_range(1));
        else pos = POS_W'($urandom_range(limit));

        if (opc == OP_SEARCH && tracker.live > 0 && $urandom_range(1) == 0)
            val = tracker.live_value();
        else
            val = rand_value();
        return make_op(opc, pos, val);
    endfunction

    task automatic drive_op(input in_t op);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_op(op);
    endtask

    initial begin
        in_t directed_ops [$];
        tracker   = new();
        idle_pct  = 0;
        stall_pct = 0;
        growing   = 1'b1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        m_ready   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_ops = '{
            make_op(OP_SEARCH, 7'd0,   32'sd0),
            make_op(OP_READ,   7'd0,   32'sd0),
            make_op(OP_DELETE, 7'd0,   32'sd0),
            make_op(OP_INSERT, 7'd1,   32'sd5),
            make_op(OP_INSERT, 7'd127, 32'sd5),
            make_op(OP_INSERT, 7'd0,   32'sh7fff_ffff),
            make_op(OP_INSERT, 7'd1,   32'sh8000_0000),
            make_op(OP_INSERT, 7'd0,   -32'sd1),
            make_op(OP_INSERT, 7'd1,   32'sd0),
            make_op(OP_READ,   7'd0,   32'sd0),
            make_op(OP_READ,   7'd1,   32'sd0),
            make_op(OP_READ,   7'd2,   32'sd0),
            make_op(OP_READ,   7'd3,   32'sd0),
            make_op(OP_READ,   7'd4,   32'sd0),
            make_op(OP_SEARCH, 7'd0,   32'sh8000_0000),
            make_op(OP_SEARCH, 7'd0,   32'sd12345),
            make_op(OP_DELETE, 7'd1,   32'sd0),
            make_op(OP_DELETE, 7'd64,  32'sd0),
            make_op(OP_UNUSED_LO,        7'd127, 32'shffff_ffff),
            make_op(OP_UNUSED_LO + 3'd1, 7'd0,   32'sd0),
            make_op(OP_UNUSED_LO + 3'd2, 7'd64,  32'sd1),
            make_op(OP_DELETE, 7'd2,   32'sd0),
            make_op(OP_CLEAR,  7'd0,   32'sd0),
            make_op(OP_READ,   7'd0,   32'sd0),
            make_op(OP_SEARCH, 7'd0,   32'sh7fff_ffff)
        };
        foreach (directed_ops[i]) drive_op(directed_ops[i]);

        for (int n = 0; n < RANDOM_OPS; n++) begin
            case (n / (RANDOM_OPS / 4))
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 47; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            drive_op(next_random_op());
        end
        s_valid <= 1'b0;

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
